// File: src/av1_obu_splitter_unit_assert.svh
// Assertion helpers for the OBU splitter top level.
// Both expect clk_i and rst_ni in scope at the point of use.
`ifndef AV1_OBU_SPLITTER_UNIT_ASSERT_SVH
`define AV1_OBU_SPLITTER_UNIT_ASSERT_SVH

// Check that cons holds in every cycle where ante holds.
`define AV1OS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond holds whenever a result is presented.
`define AV1OS_ASSERT_RESULT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> (cond)) \
    else $error(msg);

`endif

// File: src/av1os_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package av1os_pkg;

  // Stream geometry
  localparam int OFFSET_WIDTH   = 32;
  localparam int MAX_SIZE_BYTES = 8;
  localparam int ACC_W          = 56;
  localparam int LEB_CAP        = ACC_W / 7;
  localparam int MAX_HDR_LEN    = 2 + MAX_SIZE_BYTES;
  localparam int QUEUE_DEPTH    = 4;

  // Parser phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_EXT     = 3'd1;
  localparam logic [2:0] PH_SIZE    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_TO_END  = 3'd4;
  localparam logic [2:0] PH_HALTED  = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_OVERSIZE  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_END_IDLE  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } obu_byte_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  obu_type;
    logic        extension_present;
    logic [31:0] start_offset;
    logic [3:0]  header_length;
    logic [31:0] total_length;
    logic        stream_end;
  } obu_result_t;

  // Byte after classification, as it travels through the queue
  typedef struct packed {
    logic [OFFSET_WIDTH-1:0] pos;
    logic [3:0]              obu_type;
    logic                    ext;
    logic                    size_flag;
    logic                    cont;
    logic [6:0]              low7;
    logic                    eos;
  } byte_info_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage
`default_nettype wire

// File: src/av1os_front.sv
`timescale 1ns / 1ps
`default_nettype none
module av1os_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire av1os_pkg::obu_byte_t  in_data_i,
  input  wire av1os_pkg::queue_status_t q_status_i,
  output logic                       push_o,
  output av1os_pkg::byte_info_t      push_data_o
);
  import av1os_pkg::*;

  logic                    stage_valid_q, stage_valid_d;
  byte_info_t              stage_q;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic                    accept;

  // Stall only while the staged request cannot move into the queue
  assign in_stall_o  = stage_valid_q && q_status_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = stage_valid_q && !q_status_i.full;
  assign push_data_o = stage_q;

  // Advance the stage and the stream position
  always_comb begin
    stage_valid_d = stage_valid_q;
    pos_d         = pos_q;
    if (accept) begin
      stage_valid_d = 1'b1;
      pos_d = in_data_i.end_of_stream ? '0 : pos_q + OFFSET_WIDTH'(1);
    end else if (push_o) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      pos_q         <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      pos_q         <= pos_d;
    end
  end

  // Decode the header fields of every byte; the back picks what it needs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.pos       <= pos_q;
      stage_q.obu_type  <= in_data_i.data_byte[6:3];
      stage_q.ext       <= in_data_i.data_byte[2];
      stage_q.size_flag <= in_data_i.data_byte[1];
      stage_q.cont      <= in_data_i.data_byte[7];
      stage_q.low7      <= in_data_i.data_byte[6:0];
      stage_q.eos       <= in_data_i.end_of_stream;
    end
  end

endmodule
`default_nettype wire

// File: src/av1os_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module av1os_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire av1os_pkg::byte_info_t push_data_i,
  input  wire logic                  pop_i,
  output av1os_pkg::byte_info_t      pop_data_o,
  output av1os_pkg::queue_status_t   status_o
);
  import av1os_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  byte_info_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.valid = (count_q != '0);
  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: src/av1os_back.sv
`timescale 1ns / 1ps
`default_nettype none
module av1os_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire av1os_pkg::queue_status_t q_status_i,
  input  wire av1os_pkg::byte_info_t   q_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output av1os_pkg::obu_result_t       out_data_o
);
  import av1os_pkg::*;

  logic [2:0]              phase_q, phase_d;
  logic [OFFSET_WIDTH-1:0] start_q, start_d;
  logic [ACC_W-1:0]        acc_q, acc_d, acc_new, rem_q, rem_d, rem_dec;
  logic [3:0]              cnt_q, cnt_d;
  logic [3:0]              type_q, type_d;
  logic                    ext_q, ext_d, has_q, has_d;
  logic [5:0]              shamt;
  logic                    emit, blank;
  logic [1:0]              status;
  obu_result_t             res;
  logic                    out_valid_q;
  obu_result_t             out_q;
  byte_info_t              it;

  assign it          = q_data_i;
  assign pop_o       = q_status_i.valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Place of the next 7-bit size group, and the payload count-down
  assign shamt   = ({2'b00, cnt_q} << 3) - {2'b00, cnt_q};
  assign acc_new = (cnt_q < 4'(LEB_CAP)) ? (acc_q | (ACC_W'(it.low7) << shamt)) : acc_q;
  assign rem_dec = rem_q - ACC_W'(1);

  // Parse one byte
  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    type_d  = type_q;
    ext_d   = ext_q;
    has_d   = has_q;
    emit    = 1'b0;
    blank   = 1'b0;
    status  = ST_COMPLETE;
    case (phase_q)
      PH_EXT: begin
        phase_d = has_q ? PH_SIZE : PH_TO_END;
        if (it.eos) begin
          emit   = 1'b1;
          status = has_q ? ST_TRUNCATED : ST_COMPLETE;
        end
      end
      PH_SIZE: begin
        acc_d = acc_new;
        cnt_d = cnt_q + 4'd1;
        if (!it.cont) begin
          rem_d = acc_new;
          if (acc_new == '0) begin
            emit    = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            phase_d = PH_PAYLOAD;
            if (it.eos) begin
              emit   = 1'b1;
              status = ST_TRUNCATED;
            end
          end
        end else if (cnt_d >= 4'(MAX_SIZE_BYTES)) begin
          emit    = 1'b1;
          status  = ST_OVERSIZE;
          phase_d = PH_HALTED;
        end else if (it.eos) begin
          emit   = 1'b1;
          status = ST_TRUNCATED;
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          emit    = 1'b1;
          phase_d = PH_HEADER;
        end else if (it.eos) begin
          emit   = 1'b1;
          status = ST_TRUNCATED;
        end
      end
      PH_TO_END: begin
        emit = it.eos;
      end
      PH_HALTED: begin
        if (it.eos) begin
          emit   = 1'b1;
          blank  = 1'b1;
          status = ST_END_IDLE;
        end
      end
      default: begin
        start_d = it.pos;
        type_d  = it.obu_type;
        ext_d   = it.ext;
        has_d   = it.size_flag;
        acc_d   = '0;
        cnt_d   = '0;
        rem_d   = '0;
        if (it.ext) begin
          phase_d = PH_EXT;
        end else begin
          phase_d = it.size_flag ? PH_SIZE : PH_TO_END;
        end
        if (it.eos) begin
          emit   = 1'b1;
          status = (!it.ext && !it.size_flag) ? ST_COMPLETE : ST_TRUNCATED;
        end
      end
    endcase
    // The last byte returns the parser to a fresh stream
    if (it.eos) begin
      phase_d = PH_HEADER;
    end
  end

  // Assemble the result from the updated OBU state
  always_comb begin
    res.status = status;
    if (blank) begin
      res.obu_type          = '0;
      res.extension_present = 1'b0;
      res.start_offset      = '0;
      res.header_length     = '0;
      res.total_length      = '0;
      res.stream_end        = 1'b1;
    end else begin
      res.obu_type          = type_d;
      res.extension_present = ext_d;
      res.start_offset      = 32'(start_d);
      res.header_length     = 4'd1 + {3'b000, ext_d} + cnt_d;
      res.total_length      = 32'(it.pos - start_d + OFFSET_WIDTH'(1));
      res.stream_end        = it.eos;
    end
  end

  // Hold parser state until a byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      start_q     <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      type_q      <= '0;
      ext_q       <= 1'b0;
      has_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        start_q <= start_d;
        acc_q   <= acc_d;
        rem_q   <= rem_d;
        cnt_q   <= cnt_d;
        type_q  <= type_d;
        ext_q   <= ext_d;
        has_q   <= has_d;
      end
      if (pop_o) begin
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output register with a new result
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

// File: src/av1_obu_splitter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// AV1 OBU splitter: takes a low-overhead AV1 bitstream one byte per request
// on the input channel (data byte plus an end-of-stream mark on the last
// byte) and gives one request on the output channel for each finished OBU:
// status, type, extension flag, start offset, header and total length, and
// whether it closes the stream. An oversized size field gives a single error
// request; the rest of that stream is dropped and its last byte gives an
// end-with-nothing-pending request. A truncated OBU errs on the last byte.
// Throughput: one byte per cycle while in_stall_o is low. A result passes
// from the front register that takes the byte causing it, through a queue
// entry, to the output register that drives out_valid_o.
// The front stage decodes each byte and tracks its position; a four-entry queue
// parts it from the parser, whose 56-bit size count-down sets the cycle.
// Reset clears the position, the parser and all valid flags; no clearing pass.
// While out_stall_i is high the output request holds, the parser stops once a
// result waits, the queue fills and then in_stall_o rises.
module av1_obu_splitter_unit (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire av1os_pkg::obu_byte_t   in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output av1os_pkg::obu_result_t      out_data_o
);
  import av1os_pkg::*;

`include "av1_obu_splitter_unit_assert.svh"

  queue_status_t q_status;
  logic          push, pop;
  byte_info_t    push_data, pop_data;

  av1os_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  av1os_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  av1os_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `AV1OS_ASSERT_RESULT(a_idle_end_blank,
      out_data_o.status != ST_END_IDLE ||
      (out_data_o.stream_end && out_data_o.header_length == 4'd0),
      "end-idle result not blank")
  `AV1OS_ASSERT_RESULT(a_hdr_len_range,
      out_data_o.status == ST_END_IDLE ||
      (out_data_o.header_length >= 4'd1 && out_data_o.header_length <= 4'(MAX_HDR_LEN)),
      "header length out of range")
  `AV1OS_ASSERT_NOW(a_oversize_len,
      out_valid_o && out_data_o.status == ST_OVERSIZE,
      out_data_o.header_length ==
      4'd1 + {3'b000, out_data_o.extension_present} + 4'(MAX_SIZE_BYTES),
      "oversize result with wrong header length")
  `AV1OS_ASSERT_NOW(a_pop_needs_data, pop, q_status.valid,
      "parser took a byte from an empty queue")

endmodule
`default_nettype wire
